FILE: hw/rtl/swmf_pkg.sv
package swmf_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned LEN_W    = 4;

  // window length after reset
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(5);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [LEN_W-1:0]           win_len_t;

endpackage

FILE: hw/rtl/swmf_sample_if.sv
interface swmf_sample_if;
  import swmf_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

FILE: hw/rtl/swmf_median_if.sv
interface swmf_median_if;
  import swmf_pkg::*;

  logic    valid;
  logic    ready;
  sample_t median;

  modport source (output valid, output median, input ready);
  modport sink   (input valid, input median, output ready);
endinterface

FILE: hw/rtl/swmf_cfg_if.sv
interface swmf_cfg_if;
  import swmf_pkg::*;

  logic     valid;
  logic     ready;
  win_len_t window_len;

  modport source (output valid, output window_len, input ready);
  modport sink   (input valid, input window_len, output ready);
endinterface

FILE: hw/rtl/swmf_cell.sv
module swmf_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned DEPTH = 9,
  parameter int unsigned CNT_W = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          shift_en,
  input  swmf_pkg::sample_t             d_in,
  input  swmf_pkg::sample_t [DEPTH-1:0] win,
  input  logic [CNT_W-1:0]              n_eff,
  input  logic [CNT_W-1:0]              target,
  output swmf_pkg::sample_t             q,
  output logic                          hit
);
  import swmf_pkg::*;

  sample_t          val_r;
  logic [CNT_W-1:0] rank;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else if (shift_en) begin
      val_r <= d_in;
    end
  end

  assign q = val_r;

  // descending rank inside the active window; ties broken by age so
  // the ranks form a permutation
  always_comb begin
    rank = '0;
    for (int j = 0; j < DEPTH; j++) begin
      if (j != IDX && CNT_W'(j) < n_eff) begin
        if ($signed(win[j]) > $signed(val_r) ||
            ($signed(win[j]) == $signed(val_r) && j < IDX)) begin
          rank = rank + CNT_W'(1);
        end
      end
    end
  end

  assign hit = (CNT_W'(IDX) < n_eff) && (rank == target);

endmodule

FILE: hw/rtl/sliding_window_median_filter_core.sv
// Running median filter over the most recent window_len samples.
//
// Channels: in_chan carries one signed 16-bit sample per transaction,
// out_chan returns one median per sample, in order. cfg_chan writes the
// 4-bit window length (reset value 5); a value of 0 acts as 1 and values
// above MAX_WINDOW act as MAX_WINDOW. cfg_chan is always ready; write it
// only while no sample is in flight.
//
// Path: an accepted sample enters the window cells, is ranked there
// combinationally, and its median is registered onto out_chan.
// Throughput: one sample per cycle while out_chan is not stalled; the
// rank stage holds one item, so the figure is set by that single stage
// and the output register.
//
// Reset clears every window slot to zero (early medians include those
// zeros), empties both stages and restores the window length.
// When the receiver stalls the median waits in the output register, one
// further sample is taken into the window, and then in_chan.ready drops
// until the output drains.
module sliding_window_median_filter_core #(
  parameter int unsigned MAX_WINDOW = 9
) (
  input  logic                 clk,
  input  logic                 rst_n,
  swmf_sample_if.sink          in_chan,
  swmf_median_if.source        out_chan,
  swmf_cfg_if.sink             cfg_chan
);
  import swmf_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int unsigned EXT_W = 6;

  // configuration
  win_len_t window_len_r;

  // window cells: slot 0 newest
  sample_t [MAX_WINDOW-1:0] win;
  logic    [MAX_WINDOW-1:0] hit;

  // pipeline control
  logic    pending_r;      // cells hold an item whose median is not yet out
  logic    out_valid_r;
  sample_t median_r;
  logic    in_fire;
  logic    move;

  logic [EXT_W-1:0] len_ext;
  logic [CNT_W-1:0] n_eff;
  logic [CNT_W-1:0] target;
  sample_t          pick;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_len_r <= LEN_RESET;
    end else if (cfg_chan.valid) begin
      window_len_r <= cfg_chan.window_len;
    end
  end

  // effective length, clamped to 1..MAX_WINDOW
  always_comb begin
    len_ext = EXT_W'(window_len_r);
    priority if (len_ext == '0) begin
      n_eff = CNT_W'(1);
    end else if (len_ext > EXT_W'(MAX_WINDOW)) begin
      n_eff = CNT_W'(MAX_WINDOW);
    end else begin
      n_eff = CNT_W'(len_ext);
    end
    target = n_eff >> 1;
  end

  // rank result moves to the output when the output is free or draining
  assign move          = pending_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !pending_r || move;
  assign in_fire       = in_chan.valid && in_chan.ready;

  // shift chain: each cell takes its neighbour's sample on a transaction
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    sample_t d_in;
    if (i == 0) begin : g_head
      assign d_in = in_chan.sample;
    end else begin : g_link
      assign d_in = win[i-1];
    end

    swmf_cell #(
      .IDX   (i),
      .DEPTH (MAX_WINDOW),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (in_fire),
      .d_in     (d_in),
      .win      (win),
      .n_eff    (n_eff),
      .target   (target),
      .q        (win[i]),
      .hit      (hit[i])
    );
  end

  // exactly one active cell holds rank n_eff/2
  always_comb begin
    pick = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      if (hit[i]) begin
        pick = pick | win[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        pending_r <= 1'b1;
      end else if (move) begin
        pending_r <= 1'b0;
      end
      if (move) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      median_r <= pick;
    end
  end

  assign out_chan.valid  = out_valid_r;
  assign out_chan.median = median_r;

endmodule

FILE: test/sliding_window_median_filter_core_test.sv
module sliding_window_median_filter_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import swmf_pkg::*;

  localparam int unsigned MAX_WIN      = 9;
  localparam int unsigned HOLD_CYCLES  = 80;     // long receiver hold-off
  localparam int unsigned CYCLE_LIMIT  = 200000; // well above the slowest clean run
  localparam int unsigned RAND_PER_PH  = 260;    // random samples per idling phase
  localparam int unsigned LEN_EVERY    = 50;     // window length rewritten this often

  // idling phases: none, sender gaps, receiver stalls, both
  typedef enum logic [1:0] {
    PH_STEADY,
    PH_SEND_GAPS,
    PH_RECV_STALLS,
    PH_BOTH
  } phase_e;

  localparam int unsigned SEND_IDLE_PCT [4] = '{0, 45, 0, 25};
  localparam int unsigned RECV_STALL_PCT[4] = '{0, 0, 45, 25};

  typedef enum logic {
    ITEM_SAMPLE,
    ITEM_WINDOW_LEN
  } item_kind_e;

  typedef struct {
    item_kind_e kind;
    sample_t    sample;
    win_len_t   len;
    phase_e     phase;
    bit         hold;     // kick off a long receiver hold-off when launched
  } pending_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  swmf_sample_if sample_bus ();
  swmf_median_if median_bus ();
  swmf_cfg_if    len_bus ();

  sliding_window_median_filter_core #(
    .MAX_WINDOW (MAX_WIN)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (sample_bus),
    .out_chan (median_bus),
    .cfg_chan (len_bus)
  );

  always #2 clk = ~clk;

  // Stimulus waiting to be offered, and medians still owed by the block.
  pending_t    pending[$];
  sample_t     median_due[$];

  // Own copy of the filter state: newest sample in slot 0.
  sample_t     win_store[MAX_WIN] = '{default: '0};
  win_len_t    len_now            = LEN_RESET;

  phase_e      cur_phase = PH_STEADY;
  logic        hold_kick = 1'b0;
  int unsigned hold_left = 0;
  int unsigned fail_count = 0;
  int unsigned cycles = 0;

  // Shift the sample into the window, rank the newest entries in
  // descending order and return the one at the middle position. A length
  // of zero acts as one, anything above the window depth as the full depth.
  function automatic sample_t push_and_rank(sample_t s);
    sample_t     ranked[MAX_WIN];
    sample_t     v;
    int unsigned n;
    int          j;
    for (int i = MAX_WIN - 1; i > 0; i--) win_store[i] = win_store[i - 1];
    win_store[0] = s;
    n = len_now;
    if (n < 1) n = 1;
    if (n > MAX_WIN) n = MAX_WIN;
    for (int i = 0; i < n; i++) begin
      v = win_store[i];
      j = i;
      while (j > 0 && ranked[j - 1] < v) begin
        ranked[j] = ranked[j - 1];
        j--;
      end
      ranked[j] = v;
    end
    return ranked[n / 2];
  endfunction

  task automatic queue_sample(sample_t s, phase_e ph, bit hold = 1'b0);
    pending.push_back('{kind: ITEM_SAMPLE, sample: s, len: '0, phase: ph, hold: hold});
  endtask

  task automatic queue_len(win_len_t l, phase_e ph);
    pending.push_back('{kind: ITEM_WINDOW_LEN, sample: '0, len: l, phase: ph, hold: 1'b0});
  endtask

  // Driver: offers one pending item at a time. A window length write is
  // only launched once every owed median has come back, so the block is
  // idle when the register changes. Each signal gets at most one
  // nonblocking assignment per edge.
  always @(posedge clk) begin : drive_proc
    pending_t it;
    logic     sample_fire;
    logic     len_fire;
    logic     s_valid;
    sample_t  s_data;
    logic     l_valid;
    win_len_t l_data;
    logic     kick;
    if (!rst_n) begin
      sample_bus.valid     <= 1'b0;
      sample_bus.sample    <= '0;
      len_bus.valid        <= 1'b0;
      len_bus.window_len   <= '0;
      hold_kick            <= 1'b0;
    end else begin
      sample_fire = sample_bus.valid && sample_bus.ready;
      len_fire    = len_bus.valid && len_bus.ready;
      kick        = 1'b0;

      // predict at acceptance, in transaction order
      if (sample_fire) median_due.push_back(push_and_rank(sample_bus.sample));
      if (len_fire) len_now = len_bus.window_len;

      if (!((sample_bus.valid && !sample_fire) || (len_bus.valid && !len_fire))) begin
        // previous transaction done (or nothing offered): pick the next one
        s_valid = 1'b0;
        s_data  = sample_bus.sample;
        l_valid = 1'b0;
        l_data  = len_bus.window_len;
        if (pending.size() != 0) begin
          it = pending[0];
          if (it.kind == ITEM_WINDOW_LEN) begin
            if (median_due.size() == 0) begin
              l_valid = 1'b1;
              l_data  = it.len;
              cur_phase <= it.phase;
              void'(pending.pop_front());
            end
          end else if ($urandom_range(99) >= SEND_IDLE_PCT[it.phase]) begin
            s_valid = 1'b1;
            s_data  = it.sample;
            kick    = it.hold;
            cur_phase <= it.phase;
            void'(pending.pop_front());
          end
        end
        sample_bus.valid   <= s_valid;
        sample_bus.sample  <= s_data;
        len_bus.valid      <= l_valid;
        len_bus.window_len <= l_data;
      end
      hold_kick <= kick;
    end
  end

  // Receiver hold-off, counted here so the driver keeps offering
  // samples while the output stays blocked and the block fills up.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_kick) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: every accepted median is checked against the oldest one owed.
  always @(posedge clk) begin : watch_proc
    sample_t want;
    if (!rst_n) begin
      median_bus.ready <= 1'b0;
    end else begin
      if (median_bus.valid && median_bus.ready) begin
        if (median_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("[%0t] unexpected median transaction: %0d", $realtime, median_bus.median);
        end else begin
          want = median_due.pop_front();
          if (median_bus.median !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("[%0t] median mismatch: expected %0d, got %0d",
                       $realtime, want, median_bus.median);
          end
        end
      end
      median_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= RECV_STALL_PCT[cur_phase]);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("sliding_window_median_filter_core_test: done, errors");
      $finish;
    end
  end

  initial begin : stim_proc
    sample_t s;
    int unsigned r;
    // known levels from time zero, before the first edge
    sample_bus.valid   = 1'b0;
    sample_bus.sample  = '0;
    len_bus.valid      = 1'b0;
    len_bus.window_len = '0;
    median_bus.ready   = 1'b0;

    // Directed: default length 5 against the reset zeros, field extremes
    queue_sample(16'sh7fff, PH_STEADY);
    queue_sample(16'sh8000, PH_STEADY);
    queue_sample(16'sh0000, PH_STEADY);
    queue_sample(-16'sd1,   PH_STEADY);
    queue_sample(16'sd1,    PH_STEADY);
    queue_sample(16'sh7fff, PH_STEADY);
    // zero length behaves as one: median is the sample itself
    queue_len(4'd0, PH_STEADY);
    queue_sample(16'sh8000, PH_STEADY);
    queue_sample(16'sh7fff, PH_STEADY);
    // oversized length saturates to full depth
    queue_len(4'd15, PH_STEADY);
    queue_sample(-16'sd5, PH_STEADY);
    queue_sample(16'sd3,  PH_STEADY);
    queue_sample(16'sd3,  PH_STEADY);
    // even length picks the lower middle value
    queue_len(4'd2, PH_STEADY);
    queue_sample(16'sd100, PH_STEADY);
    queue_sample(-16'sd100, PH_STEADY);
    queue_len(4'd8, PH_STEADY);
    queue_sample(16'sd7, PH_STEADY);
    queue_sample(16'sd7, PH_STEADY);
    // length change: window spans the newest samples at once
    queue_len(4'd9, PH_STEADY);
    queue_sample(16'sh8000, PH_STEADY);
    queue_len(4'd1, PH_STEADY);
    queue_sample(16'sd42, PH_STEADY);

    // Random phases, length rewritten at intervals (mostly in range,
    // sometimes zero or oversized), one long hold-off in two of them.
    for (int p = 0; p < 4; p++) begin
      for (int k = 0; k < RAND_PER_PH; k++) begin
        if (k % LEN_EVERY == 0)
          queue_len(($urandom_range(99) < 75) ? win_len_t'($urandom_range(MAX_WIN, 1))
                                              : win_len_t'($urandom_range(15)),
                    phase_e'(p));
        r = $urandom_range(99);
        if (r < 10) begin
          case ($urandom_range(3))
            0:       s = 16'sh8000;
            1:       s = 16'sh7fff;
            2:       s = 16'sh0000;
            default: s = -16'sd1;
          endcase
        end else if (r < 35) begin
          s = sample_t'(int'($urandom_range(8)) - 4); // small values force ties
        end else begin
          s = sample_t'($urandom);
        end
        queue_sample(s, phase_e'(p),
                     (k == 40) && (phase_e'(p) == PH_STEADY || phase_e'(p) == PH_BOTH));
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // drain: everything offered, then every median back, then settle
    while (pending.size() != 0 || sample_bus.valid || len_bus.valid) @(posedge clk);
    while (median_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (fail_count == 0)
      $display("sliding_window_median_filter_core_test: done, clean");
    else
      $display("sliding_window_median_filter_core_test: done, errors");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/swmf_pkg.sv
hw/rtl/swmf_sample_if.sv
hw/rtl/swmf_median_if.sv
hw/rtl/swmf_cfg_if.sv
hw/rtl/swmf_cell.sv
hw/rtl/sliding_window_median_filter_core.sv
test/sliding_window_median_filter_core_test.sv
